/* design/max_pool_with_argmax_assert.svh */
// ----------------------------------------------------------------------------
// max_pool_with_argmax assertion macros
// Shared property forms for the pooling block's checks.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_WITH_ARGMAX_ASSERT_SVH
`define MAX_POOL_WITH_ARGMAX_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mpa_pkg.sv */
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and constants of the max pooling with argmax block.
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_POOL_DEF     = 8;
    localparam int MAX_CHANNELS_DEF = 1024;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int HEIGHT_W     = 11;   // holds HEIGHT_LIMIT itself
    localparam int ROW_W        = 10;   // row counter

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 30;

    localparam logic [VALUE_W-1:0] FLOOR_Q16 = 32'hFC19_0000;   // -999.0

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int POOL_CFG_W = 4;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_SIZE      = 3'd0,
        CFG_INPUT_WIDTH    = 3'd1,
        CFG_INPUT_HEIGHT   = 3'd2,
        CFG_INPUT_CHANNELS = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic init;       // first sample of its window
        logic emit;       // last sample of its window
        logic map_last;   // window is the last of the map
    } t_item_flags;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pooled_value;
        logic [INDEX_W-1:0]        winner_index;
        logic                      index_valid;
        logic                      map_last;
    } t_result;

endpackage

/* design/max_pool_with_argmax.sv */
// ----------------------------------------------------------------------------
// max_pool_with_argmax
// Streaming 2-D max pooling with argmax over a channel-major raster map.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------------
//  samples   | in        | push / full                   | i_sample_value
//  results   | out       | empty / pop                   | o_pooled_value, o_winner_index,
//            |           |                               | o_index_valid, o_map_last
//  config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  Throughput is one sample per cycle while full is low; the row store takes one read
//  and one write a cycle, with a bypass when consecutive samples land on the same
//  column entry. With both queues empty, a window result passes the item queue, then
//  the store read and compare stage, then the result queue before it is on the result
//  ports; items already queued hold it back further. Reset is synchronous; the row
//  store needs no clearing since every window seeds its entry on its first sample.
//  Config is always ready; a write to one of the four known indices restarts the
//  raster position. When pop stays low the 4-deep result queue fills, the back end
//  stops draining the 4-deep item queue, and full rises once that queue is full.
//
module max_pool_with_argmax #(
    parameter int MAX_WIDTH    = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_POOL     = mpa_pkg::MAX_POOL_DEF,
    parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // sample input
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [mpa_pkg::VALUE_W-1:0]     i_sample_value,

    // pooled results
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [mpa_pkg::VALUE_W-1:0]     o_pooled_value,
    output logic [mpa_pkg::INDEX_W-1:0]            o_winner_index,
    output logic                                   o_index_valid,
    output logic                                   o_map_last,

    // register writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [mpa_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int VW    = mpa_pkg::VALUE_W;
    localparam int IW    = mpa_pkg::INDEX_W;
    localparam int FW    = $bits(mpa_pkg::t_item_flags);
    localparam int MIDW  = VW + IW + XW + FW;
    localparam int MDEP  = mpa_pkg::MID_DEPTH;

    mpa_pkg::t_cfg_write  cfg;
    logic                 in_accept;

    // front -> item queue
    logic                 item_push;
    logic signed [VW-1:0] item_value;
    logic [IW-1:0]        item_flat;
    logic [XW-1:0]        item_addr;
    mpa_pkg::t_item_flags item_flags;

    // item queue -> back
    logic [MIDW-1:0]      mid_head;
    logic                 mid_full, mid_empty, mid_pop;
    logic [$clog2(MDEP+1)-1:0] mid_count;
    logic signed [VW-1:0] head_value;
    logic [IW-1:0]        head_flat;
    logic [XW-1:0]        head_addr;
    mpa_pkg::t_item_flags head_flags;

    mpa_pkg::t_result     res;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // full only reflects the item queue, so it never depends on the sample itself
    assign full      = mid_full;
    assign in_accept = push && !mid_full;

    mpa_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_POOL     (MAX_POOL),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (in_accept),
        .i_sample_value (i_sample_value),
        .o_item_push    (item_push),
        .o_item_value   (item_value),
        .o_item_flat    (item_flat),
        .o_item_addr    (item_addr),
        .o_item_flags   (item_flags)
    );

    // samples outside any full window never enter the queue
    mpa_fifo #(
        .WIDTH (MIDW),
        .DEPTH (MDEP)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  ({item_value, item_flat, item_addr, item_flags}),
        .i_pop   (mid_pop),
        .o_data  (mid_head),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign {head_value, head_flat, head_addr, head_flags} = mid_head;

    mpa_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!mid_empty),
        .i_head_value (head_value),
        .i_head_flat  (head_flat),
        .i_head_addr  (head_addr),
        .i_head_flags (head_flags),
        .o_head_pop   (mid_pop),
        .o_res        (res),
        .o_res_empty  (empty),
        .i_res_pop    (pop)
    );

    assign o_pooled_value = res.pooled_value;
    assign o_winner_index = res.winner_index;
    assign o_index_valid  = res.index_valid;
    assign o_map_last     = res.map_last;

    // the queue count is only used for this check
    `MPA_ASSERT_NOW(a_top_empty_count, i_clk, i_rst_n, 1'b1, mid_empty == (mid_count == '0), "max_pool_with_argmax: item queue flags disagree with count")

endmodule

/* design/mpa_ram.sv */
// ----------------------------------------------------------------------------
// mpa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mpa_fifo.sv */
// ----------------------------------------------------------------------------
// mpa_fifo
// Small flip-flop queue, first word visible at the head.
// ----------------------------------------------------------------------------
`include "max_pool_with_argmax_assert.svh"

module mpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // writers check room before pushing; a dropped item would be lost silently
    `MPA_ASSERT_NOW(a_fifo_no_overflow, i_clk, i_rst_n, o_full, !i_push, "mpa_fifo: push while full")

endmodule

/* design/mpa_front.sv */
// ----------------------------------------------------------------------------
// mpa_front
// Config registers, raster position tracking and window classification.
// ----------------------------------------------------------------------------
`include "max_pool_with_argmax_assert.svh"

module mpa_front #(
    parameter int MAX_WIDTH    = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_POOL     = mpa_pkg::MAX_POOL_DEF,
    parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpa_pkg::t_cfg_write                 i_cfg,
    input  logic                                i_accept,
    input  logic signed [mpa_pkg::VALUE_W-1:0]  i_sample_value,
    output logic                                o_item_push,
    output logic signed [mpa_pkg::VALUE_W-1:0]  o_item_value,
    output logic [mpa_pkg::INDEX_W-1:0]         o_item_flat,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_item_addr,
    output mpa_pkg::t_item_flags                o_item_flags
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WDW  = $clog2(MAX_WIDTH + 1);
    localparam int PW   = $clog2(MAX_POOL + 1);
    localparam int PHW  = $clog2(MAX_POOL);
    localparam int CHW  = $clog2(MAX_CHANNELS + 1);
    localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HW   = mpa_pkg::HEIGHT_W;
    localparam int YW   = mpa_pkg::ROW_W;
    localparam int CCW  = (WDW > PW + 1) ? WDW : PW + 1;
    localparam int RCW  = (HW > PW + 1) ? HW : PW + 1;
    localparam int IW   = mpa_pkg::INDEX_W;

    // effective (clamped) geometry
    logic [PW-1:0]  r_pool;
    logic [WDW-1:0] r_wd;
    logic [HW-1:0]  r_ht;
    logic [CHW-1:0] r_ch;

    // position
    logic [XW-1:0]  r_x, n_x;
    logic [YW-1:0]  r_y, n_y;
    logic [CW-1:0]  r_c, n_c;
    logic [PHW-1:0] r_cphase, n_cphase;
    logic [PHW-1:0] r_rphase, n_rphase;
    logic [XW-1:0]  r_ox, n_ox;
    logic [IW-1:0]  r_flat, n_flat;
    logic           r_col_full, r_col_last, r_row_full, r_row_last;

    logic           cfg_hit;
    logic [31:0]    pool_raw, dim_raw;
    logic [31:0]    pool_eff, wd_eff, ht_eff, ch_eff;

    logic           last_col, last_row, last_ch, cwrap, rwrap;
    logic           col_start, row_start;
    logic [WDW-1:0] left_col;
    logic [HW-1:0]  left_row;
    logic           col_full_now, col_last_now, row_full_now, row_last_now;

    // register write decode with range clamping
    always_comb begin
        pool_raw = 32'(i_cfg.data[mpa_pkg::POOL_CFG_W-1:0]);
        dim_raw  = 32'(i_cfg.data);

        if (pool_raw == 32'd0) begin
            pool_eff = 32'd1;
        end else if (pool_raw > 32'(MAX_POOL)) begin
            pool_eff = 32'(MAX_POOL);
        end else begin
            pool_eff = pool_raw;
        end

        if (dim_raw == 32'd0) begin
            wd_eff = 32'd1;
        end else if (dim_raw > 32'(MAX_WIDTH)) begin
            wd_eff = 32'(MAX_WIDTH);
        end else begin
            wd_eff = dim_raw;
        end

        if (dim_raw == 32'd0) begin
            ht_eff = 32'd1;
        end else if (dim_raw > 32'(mpa_pkg::HEIGHT_LIMIT)) begin
            ht_eff = 32'(mpa_pkg::HEIGHT_LIMIT);
        end else begin
            ht_eff = dim_raw;
        end

        if (dim_raw == 32'd0) begin
            ch_eff = 32'd1;
        end else if (dim_raw > 32'(MAX_CHANNELS)) begin
            ch_eff = 32'(MAX_CHANNELS);
        end else begin
            ch_eff = dim_raw;
        end

        cfg_hit = i_cfg.valid &&
                  (i_cfg.index == mpa_pkg::CFG_POOL_SIZE ||
                   i_cfg.index == mpa_pkg::CFG_INPUT_WIDTH ||
                   i_cfg.index == mpa_pkg::CFG_INPUT_HEIGHT ||
                   i_cfg.index == mpa_pkg::CFG_INPUT_CHANNELS);
    end

    // window membership of the current sample
    always_comb begin
        col_start = (r_cphase == '0);
        row_start = (r_x == '0) && (r_rphase == '0);
        left_col  = r_wd - WDW'(r_x);
        left_row  = r_ht - HW'(r_y);

        col_full_now = col_start ? (CCW'(left_col) >= CCW'(r_pool)) : r_col_full;
        col_last_now = col_start ? (CCW'(left_col) < (CCW'(r_pool) << 1)) : r_col_last;
        row_full_now = row_start ? (RCW'(left_row) >= RCW'(r_pool)) : r_row_full;
        row_last_now = row_start ? (RCW'(left_row) < (RCW'(r_pool) << 1)) : r_row_last;
    end

    // position advance
    always_comb begin
        last_col = ((WDW'(r_x) + WDW'(1)) == r_wd);
        last_row = ((HW'(r_y) + HW'(1)) == r_ht);
        last_ch  = ((CHW'(r_c) + CHW'(1)) == r_ch);
        cwrap    = ((PW'(r_cphase) + PW'(1)) == r_pool);
        rwrap    = ((PW'(r_rphase) + PW'(1)) == r_pool);

        n_y      = r_y;
        n_c      = r_c;
        n_rphase = r_rphase;

        if (last_col) begin
            n_x      = '0;
            n_cphase = '0;
            n_ox     = '0;
            n_y      = last_row ? '0 : r_y + YW'(1);
            n_rphase = (last_row || rwrap) ? '0 : r_rphase + PHW'(1);
            if (last_row) begin
                n_c = last_ch ? '0 : r_c + CW'(1);
            end
        end else begin
            n_x      = r_x + XW'(1);
            n_cphase = cwrap ? '0 : r_cphase + PHW'(1);
            n_ox     = cwrap ? r_ox + XW'(1) : r_ox;
        end

        n_flat = (last_col && last_row && last_ch) ? '0 : r_flat + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool     <= PW'(2);
            r_wd       <= WDW'(1);
            r_ht       <= HW'(1);
            r_ch       <= CHW'(1);
            r_x        <= '0;
            r_y        <= '0;
            r_c        <= '0;
            r_cphase   <= '0;
            r_rphase   <= '0;
            r_ox       <= '0;
            r_flat     <= '0;
            r_col_full <= 1'b0;
            r_col_last <= 1'b0;
            r_row_full <= 1'b0;
            r_row_last <= 1'b0;
        end else if (cfg_hit) begin
            unique case (i_cfg.index)
                mpa_pkg::CFG_POOL_SIZE:      r_pool <= PW'(pool_eff);
                mpa_pkg::CFG_INPUT_WIDTH:    r_wd   <= WDW'(wd_eff);
                mpa_pkg::CFG_INPUT_HEIGHT:   r_ht   <= HW'(ht_eff);
                mpa_pkg::CFG_INPUT_CHANNELS: r_ch   <= CHW'(ch_eff);
                default:                     r_pool <= r_pool;
            endcase
            r_x      <= '0;
            r_y      <= '0;
            r_c      <= '0;
            r_cphase <= '0;
            r_rphase <= '0;
            r_ox     <= '0;
            r_flat   <= '0;
        end else if (i_accept) begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_c        <= n_c;
            r_cphase   <= n_cphase;
            r_rphase   <= n_rphase;
            r_ox       <= n_ox;
            r_flat     <= n_flat;
            r_col_full <= col_full_now;
            r_col_last <= col_last_now;
            r_row_full <= row_full_now;
            r_row_last <= row_last_now;
        end
    end

    assign o_item_push           = i_accept && col_full_now && row_full_now;
    assign o_item_value          = i_sample_value;
    assign o_item_flat           = r_flat;
    assign o_item_addr           = r_ox;
    assign o_item_flags.init     = (r_cphase == '0) && (r_rphase == '0);
    assign o_item_flags.emit     = cwrap && rwrap;
    assign o_item_flags.map_last = last_ch && col_last_now && row_last_now;

    `MPA_ASSERT_NOW(a_front_phase_range, i_clk, i_rst_n, 1'b1, (PW'(r_cphase) < r_pool) && (PW'(r_rphase) < r_pool), "mpa_front: window phase outside pool size")

endmodule

/* design/mpa_back.sv */
// ----------------------------------------------------------------------------
// mpa_back
// Row store read-compare-write with bypass, and the result queue.
// ----------------------------------------------------------------------------
`include "max_pool_with_argmax_assert.svh"

module mpa_back #(
    parameter int MAX_WIDTH = mpa_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  logic signed [mpa_pkg::VALUE_W-1:0]  i_head_value,
    input  logic [mpa_pkg::INDEX_W-1:0]         i_head_flat,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_head_addr,
    input  mpa_pkg::t_item_flags                i_head_flags,
    output logic                                o_head_pop,
    output mpa_pkg::t_result                    o_res,
    output logic                                o_res_empty,
    input  logic                                i_res_pop
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int VW    = mpa_pkg::VALUE_W;
    localparam int IW    = mpa_pkg::INDEX_W;
    localparam int EW    = VW + IW + 1;    // stored max plus valid-tagged index
    localparam int ODEP  = mpa_pkg::OUT_DEPTH;
    localparam int OCW   = $clog2(ODEP + 1);

    // compare stage
    logic                 r_s1_valid;
    logic signed [VW-1:0] r_s1_value;
    logic [IW-1:0]        r_s1_flat;
    logic [XW-1:0]        r_s1_addr;
    mpa_pkg::t_item_flags r_s1_flags;

    // bypass for back-to-back hits on the same column entry
    logic                 r_fwd;
    logic [VW-1:0]        r_fwd_max;
    logic [IW:0]          r_fwd_idx;

    logic [EW-1:0]        ram_rdata;
    logic [VW-1:0]        cur_max, new_max;
    logic [IW:0]          cur_idx, new_idx;
    logic                 take;

    logic                 res_push, res_full;
    logic [OCW-1:0]       res_count;
    mpa_pkg::t_result     res_in;

    always_comb begin
        if (r_s1_flags.init) begin
            cur_max = mpa_pkg::FLOOR_Q16;
            cur_idx = '0;
        end else if (r_fwd) begin
            cur_max = r_fwd_max;
            cur_idx = r_fwd_idx;
        end else begin
            cur_max = ram_rdata[VW-1:0];
            cur_idx = ram_rdata[EW-1:VW];
        end
        take    = (r_s1_value > $signed(cur_max));
        new_max = take ? r_s1_value : cur_max;
        new_idx = take ? {1'b1, r_s1_flat} : cur_idx;
    end

    assign res_push              = r_s1_valid && r_s1_flags.emit;
    assign res_in.pooled_value   = $signed(new_max);
    assign res_in.winner_index   = new_idx[IW-1:0];
    assign res_in.index_valid    = new_idx[IW];
    assign res_in.map_last       = r_s1_flags.map_last;

    // room must remain for the item in the compare stage and the one behind it
    assign o_head_pop = i_head_valid &&
                        ((int'(res_count) + int'(res_push)) < ODEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= o_head_pop;
            r_fwd      <= o_head_pop && r_s1_valid && (i_head_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            r_s1_value <= i_head_value;
            r_s1_flat  <= i_head_flat;
            r_s1_addr  <= i_head_addr;
            r_s1_flags <= i_head_flags;
        end
        r_fwd_max <= new_max;
        r_fwd_idx <= new_idx;
    end

    mpa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({new_idx, new_max}),
        .i_re    (o_head_pop),
        .i_raddr (i_head_addr),
        .o_rdata (ram_rdata)
    );

    mpa_fifo #(
        .WIDTH ($bits(mpa_pkg::t_result)),
        .DEPTH (ODEP)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_full  (res_full),
        .o_empty (o_res_empty),
        .o_count (res_count)
    );

    `MPA_ASSERT_NOW(a_back_res_room, i_clk, i_rst_n, res_push, !res_full, "mpa_back: result queue full at window end")
    `MPA_ASSERT_NEXT(a_back_bypass, i_clk, i_rst_n, o_head_pop && r_s1_valid && (i_head_addr == r_s1_addr), r_fwd && r_s1_valid, "mpa_back: same-entry hit not bypassed")

endmodule

/* bench/max_pool_with_argmax_checker.sv */
// ----------------------------------------------------------------------------
// max_pool_with_argmax_checker
// Watches the sample, result and register channels of the pooling block,
// predicts every pooled window and compares it field by field.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_checker
    import mpa_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         push,
    input  logic                         full,
    input  logic signed [VALUE_W-1:0]    i_sample_value,

    input  logic                         empty,
    input  logic                         pop,
    input  logic signed [VALUE_W-1:0]    o_pooled_value,
    input  logic [INDEX_W-1:0]           o_winner_index,
    input  logic                         o_index_valid,
    input  logic                         o_map_last,

    input  logic                         i_cfg_valid,
    input  logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    output int                           o_fail_count,
    output int                           o_pending_count,
    output int                           o_window_count
);

    // register copies
    logic [POOL_CFG_W-1:0]  pool_reg;
    logic [CFG_DATA_W-1:0]  width_reg;
    logic [CFG_DATA_W-1:0]  height_reg;
    logic [CFG_DATA_W-1:0]  chan_reg;

    // running maximum and winner (valid flag on top) per output column
    logic [VALUE_W-1:0]     best_value [MAX_WIDTH_DEF];
    logic [INDEX_W:0]       best_index [MAX_WIDTH_DEF];

    int unsigned            col, row, chan, col_phase, row_phase;
    t_result                pending_windows [$];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic restart_raster();
        col       = 0;
        row       = 0;
        chan      = 0;
        col_phase = 0;
        row_phase = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_POOL_SIZE:      pool_reg   = data[POOL_CFG_W-1:0];
            CFG_INPUT_WIDTH:    width_reg  = data;
            CFG_INPUT_HEIGHT:   height_reg = data;
            CFG_INPUT_CHANNELS: chan_reg   = data;
            default:            return;     // unknown index: no effect at all
        endcase
        restart_raster();
    endtask

    task automatic fold_sample(logic [VALUE_W-1:0] v);
        int unsigned     pool, wd, ht, ch, ox, oy;
        longint unsigned flat;
        t_result         win;
        pool = clamp_dim(pool_reg, MAX_POOL_DEF);
        wd   = clamp_dim(width_reg, MAX_WIDTH_DEF);
        ht   = clamp_dim(height_reg, HEIGHT_LIMIT);
        ch   = clamp_dim(chan_reg, MAX_CHANNELS_DEF);
        ox   = col / pool;
        oy   = row / pool;
        if (ox < wd / pool && oy < ht / pool) begin
            if (col_phase == 0 && row_phase == 0) begin
                best_value[ox] = FLOOR_Q16;
                best_index[ox] = '0;
            end
            if ($signed(v) > $signed(best_value[ox])) begin
                flat = (longint'(chan) * ht + row) * wd + col;
                best_value[ox] = v;
                best_index[ox] = {1'b1, flat[INDEX_W-1:0]};
            end
            if (col_phase == pool - 1 && row_phase == pool - 1) begin
                win.pooled_value = best_value[ox];
                win.winner_index = best_index[ox][INDEX_W-1:0];
                win.index_valid  = best_index[ox][INDEX_W];
                win.map_last     = (chan == ch - 1) && (oy == ht / pool - 1)
                                   && (ox == wd / pool - 1);
                pending_windows.push_back(win);
            end
        end
        // step the raster position
        col++;
        col_phase++;
        if (col_phase >= pool) col_phase = 0;
        if (col >= wd) begin
            col       = 0;
            col_phase = 0;
            row++;
            row_phase++;
            if (row_phase >= pool) row_phase = 0;
            if (row >= ht) begin
                row       = 0;
                row_phase = 0;
                chan++;
                if (chan >= ch) chan = 0;
            end
        end
    endtask

    task automatic compare_field(string field, logic [VALUE_W-1:0] want,
                                 logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_window();
        t_result want;
        if (pending_windows.size() == 0) begin
            $error("pooled result %h / index %h arrived with nothing expected",
                   o_pooled_value, o_winner_index);
            o_fail_count++;
            return;
        end
        want = pending_windows.pop_front();
        compare_field("pooled_value", want.pooled_value, o_pooled_value);
        compare_field("winner_index", VALUE_W'(want.winner_index), VALUE_W'(o_winner_index));
        compare_field("index_valid", VALUE_W'(want.index_valid), VALUE_W'(o_index_valid));
        compare_field("map_last", VALUE_W'(want.map_last), VALUE_W'(o_map_last));
        o_window_count++;
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        o_window_count  = 0;
    end

    // results are checked before the same edge's sample is folded in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool_reg   = 4'd2;
            width_reg  = 11'd1;
            height_reg = 11'd1;
            chan_reg   = 11'd1;
            restart_raster();
            pending_windows.delete();
        end else begin
            if (pop && !empty) check_window();
            if (i_cfg_valid && o_cfg_ready) write_reg(i_cfg_index, i_cfg_data);
            if (push && !full) fold_sample(i_sample_value);
        end
        o_pending_count = pending_windows.size();
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the pooling block through directed windows, clamped boundary maps and
// random maps under several idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    import mpa_pkg::*;

    localparam int     SETTLE_CYCLES  = 16;      // item queue + pipeline, with margin
    localparam int     RANDOM_SAMPLES = 560;
    localparam longint RUN_LIMIT      = 64'd4_000_000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        push;
    logic                        full;
    logic signed [VALUE_W-1:0]   i_sample_value;
    logic                        empty;
    logic                        pop;
    logic signed [VALUE_W-1:0]   o_pooled_value;
    logic [INDEX_W-1:0]          o_winner_index;
    logic                        o_index_valid;
    logic                        o_map_last;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    int                          fail_count;
    int                          pending_count;
    int                          window_count;

    // idling odds in percent, changed only between phases
    int unsigned                 send_gap_pct;
    int unsigned                 pop_stall_pct;

    int                          samples_sent;
    int                          settings_used;

    max_pool_with_argmax dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_sample_value (i_sample_value),
        .empty          (empty),
        .pop            (pop),
        .o_pooled_value (o_pooled_value),
        .o_winner_index (o_winner_index),
        .o_index_valid  (o_index_valid),
        .o_map_last     (o_map_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    max_pool_with_argmax_checker pool_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_value  (i_sample_value),
        .empty           (empty),
        .pop             (pop),
        .o_pooled_value  (o_pooled_value),
        .o_winner_index  (o_winner_index),
        .o_index_valid   (o_index_valid),
        .o_map_last      (o_map_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_window_count  (window_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #(RUN_LIMIT);
        $display("max_pool_with_argmax verification failed");
        $finish;
    end

    // Receiver: pop is redrawn every cycle; stretches with no stall come from
    // the IDLE_NONE and IDLE_SENDER phases.
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    task automatic pick_idling(int unsigned phase_no);
        case (t_idle'(phase_no % 4))
            IDLE_NONE:     begin send_gap_pct = 0;  pop_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 48; pop_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  pop_stall_pct = 48; end
            default:       begin send_gap_pct = 14; pop_stall_pct = 14; end
        endcase
    endtask

    // Push stays high after an accepted item so back-to-back items never see
    // a low/high pair of assignments in one step; a drawn gap in the next call
    // or wait_quiet() lowers it.
    task automatic push_sample(logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (full);
        samples_sent++;
    endtask

    // Leaves valid high; end_writes() drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic set_map(logic [CFG_DATA_W-1:0] pool_data, logic [CFG_DATA_W-1:0] w_data,
                           logic [CFG_DATA_W-1:0] h_data, logic [CFG_DATA_W-1:0] c_data);
        write_reg(CFG_POOL_SIZE, pool_data);
        write_reg(CFG_INPUT_WIDTH, w_data);
        write_reg(CFG_INPUT_HEIGHT, h_data);
        write_reg(CFG_INPUT_CHANNELS, c_data);
        end_writes();
    endtask

    // Idle point: every expected window is back (polled at the falling edge,
    // after the checker's update), then let any result-less items still
    // queued in the block drain before touching a register.
    task automatic wait_quiet();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sample mix: low_pct of the draws sit at or below the -999 floor, the
    // rest hit full range, ties, the largest word and small values.
    function automatic logic [VALUE_W-1:0] make_sample(int unsigned low_pct);
        int unsigned      pick;
        logic [17:0]      narrow;
        pick   = $urandom_range(99);
        narrow = 18'($urandom);
        if (pick < low_pct) begin
            case ($urandom_range(3))
                0:       return FLOOR_Q16;
                1:       return FLOOR_Q16 - 1;
                2:       return 32'h8000_0000;
                default: return $urandom_range(32'hFC19_0000, 32'h8000_0000);
            endcase
        end
        case ($urandom_range(5))
            0:       return FLOOR_Q16 + 1;
            1:       return 32'h7FFF_FFFF;
            2:       return VALUE_W'($urandom_range(3)) << 16;   // frequent ties
            3:       return {{(VALUE_W-18){narrow[17]}}, narrow};
            default: return $urandom;
        endcase
    endfunction

    // pool register data for an effective size; 0 and 9..15 clamp, top bits ignored
    function automatic logic [CFG_DATA_W-1:0] pool_data_for(int unsigned p);
        logic [POOL_CFG_W-1:0] nib;
        nib = POOL_CFG_W'(p);
        if (p == 1 && $urandom_range(1)) nib = '0;
        if (p == MAX_POOL_DEF && $urandom_range(1)) nib = POOL_CFG_W'($urandom_range(9, 15));
        if ($urandom_range(1))
            return {(CFG_DATA_W-POOL_CFG_W)'($urandom), nib};
        return CFG_DATA_W'(nib);
    endfunction

    // dimension data; size 1 is sometimes written as 0
    function automatic logic [CFG_DATA_W-1:0] dim_data_for(int unsigned d);
        if (d == 1 && $urandom_range(1)) return '0;
        return CFG_DATA_W'(d);
    endfunction

    initial begin
        int unsigned cur_pool, cur_w, cur_h, cur_c;
        int unsigned map_items, batch, choice, low_pct, phase_no;
        int unsigned clamp_pick;
        logic [3:0]  mask;
        int          random_sent;

        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_sample_value = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_gap_pct   = 0;
        pop_stall_pct  = 0;
        samples_sent   = 0;
        settings_used  = 0;
        random_sent    = 0;
        phase_no       = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----------------------------------------------------
        // Reset setting is pool 2 over a 1x1 plane: window bigger than the
        // plane, so nothing may come out.
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        wait_quiet();

        // 4x2 plane, pool 2. Left window never beats the floor (floor,
        // most negative, one LSB below floor). Right window has a tie at the
        // positive extreme: the earlier sample (x=3, y=0) must win.
        pick_idling(IDLE_SENDER);
        set_map(11'd2, 11'd4, 11'd2, 11'd1);
        push_sample(FLOOR_Q16);
        push_sample(32'h8000_0000);
        push_sample(32'h0005_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(FLOOR_Q16 - 1);
        push_sample(FLOOR_Q16);
        push_sample(32'h7FFF_FFFF);
        push_sample(FLOOR_Q16 + 1);
        wait_quiet();

        // Ragged edge: pool 3 over 4x3, column 3 is dropped even though it
        // holds the largest value.
        pick_idling(IDLE_RECEIVER);
        set_map(11'd3, 11'd4, 11'd3, 11'd1);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                push_sample((x == 3) ? 32'h7FFF_FFFF : make_sample(20));
        wait_quiet();

        // pool written as 0 behaves as 1
        pick_idling(IDLE_BOTH);
        set_map(11'd0, 11'd2, 11'd1, 11'd1);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_0000);
        wait_quiet();

        // ---- boundary map ------------------------------------------------
        // One register beyond its limit, picked per seed. Pool 1 over a map of
        // 1024 samples only when clamped, so map_last lands on sample 1023 and
        // the raster wraps right after it.
        clamp_pick = $urandom_range(2);
        pick_idling(clamp_pick);
        case (clamp_pick)
            0:       set_map(11'h7F0, 11'h7FF, 11'd1, 11'd1);    // width clamps to 1024
            1:       set_map(11'd1, 11'd1, 11'd1500, 11'd1);     // height clamps to 1024
            default: set_map(11'd1, 11'd0, 11'd0, 11'h7FF);      // channels clamp to 1024
        endcase
        repeat (1026) push_sample(make_sample(20));
        wait_quiet();

        // ---- random maps -------------------------------------------------
        // Mostly fresh small maps sent whole (sometimes twice, to cross the
        // end-of-map wrap), some partial, some continued without a restart
        // or after a write to an unused index, which must not restart.
        cur_pool = 1;
        cur_w    = 1;
        cur_h    = 1;
        cur_c    = 1;
        while (random_sent < RANDOM_SAMPLES) begin
            pick_idling(phase_no);
            choice = $urandom_range(99);
            if (phase_no == 0 || choice < 80) begin
                mask = (phase_no == 0) ? 4'hF : 4'($urandom_range(1, 15));
                if (mask[0]) begin
                    cur_pool = ($urandom_range(3) != 0) ? $urandom_range(1, 4)
                                                        : $urandom_range(5, MAX_POOL_DEF);
                    write_reg(CFG_POOL_SIZE, pool_data_for(cur_pool));
                end
                if (mask[1]) begin
                    cur_w = $urandom_range(1, 2 * cur_pool + 3);
                    write_reg(CFG_INPUT_WIDTH, dim_data_for(cur_w));
                end
                if (mask[2]) begin
                    cur_h = $urandom_range(1, cur_pool + 3);
                    write_reg(CFG_INPUT_HEIGHT, dim_data_for(cur_h));
                end
                if (mask[3]) begin
                    cur_c = $urandom_range(1, 3);
                    write_reg(CFG_INPUT_CHANNELS, dim_data_for(cur_c));
                end
                end_writes();
            end else if (choice < 90) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_INPUT_CHANNELS + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
                end_writes();
            end

            // keep maps small; a large pool size above may have grown them
            map_items = cur_w * cur_h * cur_c;
            if (map_items > 240) map_items = 240;
            if ($urandom_range(99) < 70)
                batch = map_items * $urandom_range(1, 2);
            else
                batch = $urandom_range(1, map_items);

            case ($urandom_range(2))
                0:       low_pct = 0;
                1:       low_pct = 20;
                default: low_pct = 85;     // many windows stay at the floor
            endcase

            repeat (batch) push_sample(make_sample(low_pct));
            random_sent += batch;
            wait_quiet();
            phase_no++;
        end

        $display("covered %0d samples over %0d register settings, %0d pooled windows compared",
                 samples_sent, settings_used, window_count);
        if (fail_count == 0 && pending_count == 0)
            $display("max_pool_with_argmax verification clean");
        else
            $display("max_pool_with_argmax verification failed");
        $finish;
    end

endmodule
